@@ hw/rtl/dhc_pkg.sv @@
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types, codes and tables of the DMA/HDMA channel controller.
// ----------------------------------------------------------------------------
package dhc_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_FRAME = 3'd2;
  localparam logic [2:0] REQ_LINE  = 3'd3;
  localparam logic [2:0] REQ_REPLY = 3'd4;

  localparam logic [3:0] SEL_CTRL  = 4'd0;
  localparam logic [3:0] SEL_BOFS  = 4'd1;
  localparam logic [3:0] SEL_AALO  = 4'd2;
  localparam logic [3:0] SEL_AAHI  = 4'd3;
  localparam logic [3:0] SEL_ABANK = 4'd4;
  localparam logic [3:0] SEL_SZLO  = 4'd5;
  localparam logic [3:0] SEL_SZHI  = 4'd6;
  localparam logic [3:0] SEL_IBANK = 4'd7;
  localparam logic [3:0] SEL_TBLO  = 4'd8;
  localparam logic [3:0] SEL_TBHI  = 4'd9;
  localparam logic [3:0] SEL_LC    = 4'd10;
  localparam logic [3:0] SEL_DMAEN = 4'd11;
  localparam logic [3:0] SEL_HDMEN = 4'd12;

  localparam logic [1:0] RK_REG  = 2'd0;
  localparam logic [1:0] RK_COPY = 2'd1;
  localparam logic [1:0] RK_TBL  = 2'd2;
  localparam logic [1:0] RK_ACK  = 2'd3;

  localparam logic [1:0] SCAN_INIT = 2'd0;
  localparam logic [1:0] SCAN_XFER = 2'd1;
  localparam logic [1:0] SCAN_UPD  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_DMA, PH_INIT, PH_INIT_CNT, PH_INIT_LO, PH_INIT_HI, PH_XFER,
    PH_UPD, PH_UPD_CNT, PH_UPD_LO, PH_UPD_HI, PH_UPD_MSB
  } phase_t;

  typedef struct packed {
    logic [7:0]  ctrl;
    logic [7:0]  bofs;
    logic [15:0] aaddr;
    logic [7:0]  abank;
    logic [7:0]  ibank;
    logic [15:0] size;
    logic [15:0] tbl;
    logic [7:0]  lc;
  } chan_rec_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] ach;
    logic [1:0] bidx;
  } eng_st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_data;
    logic [23:0] addr_a;
    logic [7:0]  b_offset;
    logic        b_to_a;
  } res_t;

  function automatic logic [2:0] xfer_len(input logic [2:0] mode);
    case (mode)
      3'd0:                   xfer_len = 3'd1;
      3'd1, 3'd2, 3'd6:       xfer_len = 3'd2;
      default:                xfer_len = 3'd4;
    endcase
  endfunction

  function automatic logic [1:0] xfer_ofs(input logic [2:0] mode, input logic [1:0] idx);
    case (mode)
      3'd1, 3'd5: xfer_ofs = {1'b0, idx[0]};
      3'd3, 3'd7: xfer_ofs = {1'b0, idx[1]};
      3'd4:       xfer_ofs = idx;
      default:    xfer_ofs = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] chan_mask(input int nch);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (i < nch) m[i] = 1'b1;
    return m;
  endfunction

  function automatic eng_st_t scan_one(input logic [3:0] start, input logic [1:0] kind,
                                       input logic [7:0] hmask, input logic [7:0] fin,
                                       input logic [7:0] dox, input int nch,
                                       output logic found);
    eng_st_t r;
    logic    q;
    r.phase = PH_IDLE;
    r.ach   = 3'd0;
    r.bidx  = 2'd0;
    found   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      q = hmask[i] && (i < nch) && (4'(i) >= start);
      if (kind == SCAN_XFER) q = q && !fin[i] && dox[i];
      if (kind == SCAN_UPD) q = q && !fin[i];
      if (q && !found) begin
        found = 1'b1;
        r.ach = 3'(i);
        r.phase = (kind == SCAN_INIT) ? PH_INIT : (kind == SCAN_XFER) ? PH_XFER : PH_UPD;
      end
    end
    return r;
  endfunction

  function automatic eng_st_t scan_from(input logic [3:0] start, input logic [1:0] kind,
                                        input logic [7:0] hmask, input logic [7:0] fin,
                                        input logic [7:0] dox, input int nch);
    eng_st_t r;
    logic    f;
    r = scan_one(start, kind, hmask, fin, dox, nch, f);
    if (!f && kind == SCAN_XFER) r = scan_one(4'd0, SCAN_UPD, hmask, fin, dox, nch, f);
    return r;
  endfunction

endpackage

@@ hw/rtl/dma_hdma_channel_controller_core.sv @@
// ----------------------------------------------------------------------------
// dma_hdma_channel_controller_core
// Eight-channel DMA/HDMA controller: register access, general DMA and
// HDMA table processing, one bus command per request word.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | content
// s_*     | in  | tvalid/tready    | request word, req_type in tuser
// m_*     | out | tvalid/tready    | result word, result_kind in tuser
//
// One request at a time. A register read passes S_RR and S_OUT, a
// register write S_WR and S_POST and, with the engine idle, engine
// steps; each step is a record read and a write-back of the channel
// store, run until one emits its result. Reset clears the store's
// valid bits. A stalled result holds the engine.
module dma_hdma_channel_controller_core #(
  parameter int CHANNELS = dhc_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // reg_channel[2:0], reg_select[6:3], write_data[14:7],
                                 // bus_data[22:15]
  input  logic [2:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // reg_data[7:0], addr_a[31:8], b_offset[39:32],
                                 // b_to_a[40], busy_res[41]
  output logic [1:0]  m_tuser    // result_kind
);
  import dhc_pkg::*;

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [7:0] VMASK = chan_mask(CHANNELS);

  typedef enum logic [2:0] {S_IDLE, S_WR, S_RR, S_POST, S_ENG, S_EX, S_OUT} st_t;

  st_t        st;
  eng_st_t    eng;
  logic [7:0] hmask, pend, fin, dox;
  logic [2:0] ch;
  logic [3:0] sel;
  logic [7:0] wd, bd;
  res_t       res;

  logic       mem_re, mem_we;
  logic [CHW-1:0] mem_raddr, mem_waddr;
  chan_rec_t  mem_wdata, mem_rdata, rec_merge;

  chan_rec_t  s_rec;
  eng_st_t    s_eng;
  logic [7:0] s_fin, s_dox, s_pend;
  logic       s_emit;
  res_t       s_res;

  logic [2:0] in_req;
  logic [2:0] in_ch;
  logic [3:0] in_sel;
  logic [7:0] in_wd;
  logic       ch_ok;
  logic [7:0] rd_byte;
  logic [7:0] pv;
  logic [2:0] low_ch;

  assign in_ch  = s_tdata[2:0];
  assign in_sel = s_tdata[6:3];
  assign in_wd  = s_tdata[14:7];
  assign in_req = s_tuser;
  assign ch_ok  = ({1'b0, in_ch} < 4'(CHANNELS)) && (in_sel <= SEL_LC);
  assign s_tready = (st == S_IDLE);
  assign pv = pend & VMASK;

  always_comb begin
    low_ch = 3'd0;
    for (int i = 7; i >= 0; i--) if (pv[i]) low_ch = 3'(i);
  end

  dhc_chan_mem #(.CHANNELS(CHANNELS), .CHW(CHW)) u_mem (
    .clk(clk), .rst(rst), .re(mem_re), .raddr(mem_raddr), .we(mem_we),
    .waddr(mem_waddr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  dhc_step #(.CHANNELS(CHANNELS)) u_step (
    .rec(mem_rdata), .eng(eng), .data(bd), .hmask(hmask), .fin(fin), .dox(dox),
    .pend(pend), .rec_next(s_rec), .eng_next(s_eng), .fin_next(s_fin),
    .dox_next(s_dox), .pend_next(s_pend), .emit(s_emit), .res(s_res)
  );

  always_comb begin
    rec_merge = mem_rdata;
    case (sel)
      SEL_CTRL:  rec_merge.ctrl = wd;
      SEL_BOFS:  rec_merge.bofs = wd;
      SEL_AALO:  rec_merge.aaddr[7:0] = wd;
      SEL_AAHI:  rec_merge.aaddr[15:8] = wd;
      SEL_ABANK: rec_merge.abank = wd;
      SEL_SZLO:  rec_merge.size[7:0] = wd;
      SEL_SZHI:  rec_merge.size[15:8] = wd;
      SEL_IBANK: rec_merge.ibank = wd;
      SEL_TBLO:  rec_merge.tbl[7:0] = wd;
      SEL_TBHI:  rec_merge.tbl[15:8] = wd;
      SEL_LC:    rec_merge.lc = wd;
      default:   rec_merge = mem_rdata;
    endcase
    case (sel)
      SEL_CTRL:  rd_byte = mem_rdata.ctrl;
      SEL_BOFS:  rd_byte = mem_rdata.bofs;
      SEL_AALO:  rd_byte = mem_rdata.aaddr[7:0];
      SEL_AAHI:  rd_byte = mem_rdata.aaddr[15:8];
      SEL_ABANK: rd_byte = mem_rdata.abank;
      SEL_SZLO:  rd_byte = mem_rdata.size[7:0];
      SEL_SZHI:  rd_byte = mem_rdata.size[15:8];
      SEL_IBANK: rd_byte = mem_rdata.ibank;
      SEL_TBLO:  rd_byte = mem_rdata.tbl[7:0];
      SEL_TBHI:  rd_byte = mem_rdata.tbl[15:8];
      SEL_LC:    rd_byte = mem_rdata.lc;
      default:   rd_byte = 8'd0;
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = eng.ach[CHW-1:0];
    mem_we    = 1'b0;
    mem_waddr = eng.ach[CHW-1:0];
    mem_wdata = s_rec;
    unique case (st)
      S_IDLE: begin
        mem_re    = s_tvalid && ch_ok && (in_req == REQ_WRITE || in_req == REQ_READ);
        mem_raddr = in_ch[CHW-1:0];
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ch[CHW-1:0];
        mem_wdata = rec_merge;
      end
      S_ENG: begin
        mem_re    = 1'b1;
        mem_raddr = (eng.phase == PH_IDLE) ? low_ch[CHW-1:0] : eng.ach[CHW-1:0];
      end
      S_EX: mem_we = !s_emit || !m_tvalid || m_tready;
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      eng      <= '{phase: PH_IDLE, ach: 3'd0, bidx: 2'd0};
      hmask    <= '0;
      pend     <= '0;
      fin      <= '0;
      dox      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && st != S_OUT) m_tvalid <= 1'b0;
      unique case (st)
        S_IDLE: if (s_tvalid) begin
          ch  <= in_ch;
          sel <= in_sel;
          wd  <= in_wd;
          bd  <= s_tdata[22:15];
          res <= '{kind: (in_req == REQ_READ) ? RK_REG : RK_ACK, default: '0};
          if (in_req == REQ_WRITE) begin
            if (in_sel == SEL_DMAEN) pend <= (pend | in_wd) & VMASK;
            if (in_sel == SEL_HDMEN) hmask <= in_wd & VMASK;
            st <= ch_ok ? S_WR : S_POST;
          end else if (in_req == REQ_READ) begin
            st <= ch_ok ? S_RR : S_OUT;
          end else if (in_req == REQ_FRAME && eng.phase == PH_IDLE) begin
            fin <= '0;
            dox <= (hmask != 8'd0) ? 8'hFF : 8'd0;
            if (hmask != 8'd0) eng <= scan_from(4'd0, SCAN_INIT, hmask, '0, 8'hFF, CHANNELS);
            st <= S_ENG;
          end else if (in_req == REQ_LINE && eng.phase == PH_IDLE) begin
            if (hmask != 8'd0) eng <= scan_from(4'd0, SCAN_XFER, hmask, fin, dox, CHANNELS);
            st <= S_ENG;
          end else if (in_req == REQ_REPLY && eng.phase != PH_IDLE) begin
            st <= S_ENG;
          end else begin
            st <= S_OUT;
          end
        end
        S_WR:   st <= S_POST;
        S_RR: begin
          res.reg_data <= rd_byte;
          st           <= S_OUT;
        end
        S_POST: st <= (eng.phase == PH_IDLE) ? S_ENG : S_OUT;
        S_ENG: begin
          if (eng.phase == PH_IDLE) begin
            if (pv == 8'd0) st <= S_OUT;
            else begin
              eng <= '{phase: PH_DMA, ach: low_ch, bidx: 2'd0};
              st  <= S_EX;
            end
          end else begin
            st <= S_EX;
          end
        end
        S_EX: if (mem_we) begin
          eng  <= s_eng;
          fin  <= s_fin;
          dox  <= s_dox;
          pend <= s_pend;
          if (s_emit) begin
            res <= s_res;
            st  <= S_OUT;
          end else begin
            st <= S_ENG;
          end
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tuser  <= res.kind;
          m_tdata  <= {6'd0, (eng.phase != PH_IDLE) || (pv != 8'd0), res.b_to_a,
                       res.b_offset, res.addr_a, res.reg_data};
          st       <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/dhc_chan_mem.sv @@
// ----------------------------------------------------------------------------
// dhc_chan_mem
// Per-channel record store, one write and one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module dhc_chan_mem #(
  parameter int CHANNELS = dhc_pkg::CHANNELS_DEF,
  parameter int CHW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               re,
  input  logic [CHW-1:0]     raddr,
  input  logic               we,
  input  logic [CHW-1:0]     waddr,
  input  dhc_pkg::chan_rec_t wdata,
  output dhc_pkg::chan_rec_t rdata
);
  import dhc_pkg::*;

  chan_rec_t          mem [CHANNELS];
  logic [CHANNELS-1:0] vld;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= vld[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/dhc_step.sv @@
// ----------------------------------------------------------------------------
// dhc_step
// One engine step on the active channel record: DMA copy, HDMA table
// fetch, HDMA copy or line counter update, and the next-channel search.
// ----------------------------------------------------------------------------
module dhc_step #(
  parameter int CHANNELS = dhc_pkg::CHANNELS_DEF
) (
  input  dhc_pkg::chan_rec_t rec,
  input  dhc_pkg::eng_st_t   eng,
  input  logic [7:0]         data,
  input  logic [7:0]         hmask,
  input  logic [7:0]         fin,
  input  logic [7:0]         dox,
  input  logic [7:0]         pend,
  output dhc_pkg::chan_rec_t rec_next,
  output dhc_pkg::eng_st_t   eng_next,
  output logic [7:0]         fin_next,
  output logic [7:0]         dox_next,
  output logic [7:0]         pend_next,
  output logic               emit,
  output dhc_pkg::res_t      res
);
  import dhc_pkg::*;

  logic       ind;
  logic [2:0] mode;
  logic [3:0] nxt;
  logic [2:0] nb;
  logic [7:0] lc_dec;
  logic [7:0] ofs;

  always_comb begin
    ind       = rec.ctrl[6];
    mode      = rec.ctrl[2:0];
    nxt       = {1'b0, eng.ach} + 4'd1;
    nb        = {1'b0, eng.bidx} + 3'd1;
    lc_dec    = rec.lc - 8'd1;
    ofs       = {6'd0, xfer_ofs(mode, eng.bidx)};
    rec_next  = rec;
    eng_next  = eng;
    fin_next  = fin;
    dox_next  = dox;
    pend_next = pend;
    emit      = 1'b0;
    res       = '0;
    unique case (eng.phase)
      PH_DMA: begin
        emit         = 1'b1;
        res.kind     = RK_COPY;
        res.addr_a   = {rec.abank, rec.aaddr};
        res.b_offset = rec.bofs + ofs;
        res.b_to_a   = rec.ctrl[7];
        if (!rec.ctrl[3]) rec_next.aaddr = rec.ctrl[4] ? rec.aaddr - 16'd1 : rec.aaddr + 16'd1;
        rec_next.size = rec.size - 16'd1;
        eng_next.bidx = eng.bidx + 2'd1;
        if (rec.size == 16'd1) begin
          pend_next[eng.ach] = 1'b0;
          eng_next.bidx      = 2'd0;
          eng_next.phase     = PH_IDLE;
        end
      end
      PH_INIT: begin
        emit           = 1'b1;
        res.kind       = RK_TBL;
        res.addr_a     = {rec.abank, rec.aaddr};
        rec_next.tbl   = rec.aaddr + 16'd1;
        eng_next.phase = PH_INIT_CNT;
      end
      PH_INIT_CNT: begin
        rec_next.lc = data;
        if (data == 8'd0) fin_next[eng.ach] = 1'b1;
        if (ind) begin
          emit           = 1'b1;
          res.kind       = RK_TBL;
          res.addr_a     = {rec.abank, rec.tbl};
          rec_next.tbl   = rec.tbl + 16'd1;
          eng_next.phase = PH_INIT_LO;
        end else begin
          eng_next = scan_from(nxt, SCAN_INIT, hmask, fin, dox, CHANNELS);
        end
      end
      PH_INIT_LO, PH_UPD_LO: begin
        rec_next.size  = {8'd0, data};
        emit           = 1'b1;
        res.kind       = RK_TBL;
        res.addr_a     = {rec.abank, rec.tbl};
        rec_next.tbl   = rec.tbl + 16'd1;
        eng_next.phase = (eng.phase == PH_INIT_LO) ? PH_INIT_HI : PH_UPD_HI;
      end
      PH_INIT_HI: begin
        rec_next.size = {data, rec.size[7:0]};
        eng_next      = scan_from(nxt, SCAN_INIT, hmask, fin, dox, CHANNELS);
      end
      PH_XFER: begin
        emit         = 1'b1;
        res.kind     = RK_COPY;
        res.b_offset = rec.bofs + ofs;
        res.b_to_a   = rec.ctrl[7];
        if (ind) begin
          res.addr_a    = {rec.ibank, rec.size};
          rec_next.size = rec.size + 16'd1;
        end else begin
          res.addr_a   = {rec.abank, rec.tbl};
          rec_next.tbl = rec.tbl + 16'd1;
        end
        if (nb >= xfer_len(mode)) eng_next = scan_from(nxt, SCAN_XFER, hmask, fin, dox, CHANNELS);
        else eng_next.bidx = nb[1:0];
      end
      PH_UPD: begin
        rec_next.lc        = lc_dec;
        dox_next[eng.ach]  = lc_dec[7];
        if (lc_dec[6:0] == 7'd0) begin
          emit           = 1'b1;
          res.kind       = RK_TBL;
          res.addr_a     = {rec.abank, rec.tbl};
          rec_next.tbl   = rec.tbl + 16'd1;
          eng_next.phase = PH_UPD_CNT;
        end else begin
          eng_next = scan_from(nxt, SCAN_UPD, hmask, fin, dox, CHANNELS);
        end
      end
      PH_UPD_CNT: begin
        rec_next.lc = data;
        if (ind) begin
          emit           = 1'b1;
          res.kind       = RK_TBL;
          res.addr_a     = {rec.abank, rec.tbl};
          rec_next.tbl   = rec.tbl + 16'd1;
          eng_next.phase = (data == 8'd0) ? PH_UPD_MSB : PH_UPD_LO;
        end else begin
          if (data == 8'd0) fin_next[eng.ach] = 1'b1;
          dox_next[eng.ach] = 1'b1;
          eng_next = scan_from(nxt, SCAN_UPD, hmask, fin, dox, CHANNELS);
        end
      end
      PH_UPD_HI, PH_UPD_MSB: begin
        rec_next.size = (eng.phase == PH_UPD_HI) ? {data, rec.size[7:0]} : {data, 8'd0};
        if (rec.lc == 8'd0) fin_next[eng.ach] = 1'b1;
        dox_next[eng.ach] = 1'b1;
        eng_next = scan_from(nxt, SCAN_UPD, hmask, fin, dox, CHANNELS);
      end
      default: begin
        emit     = 1'b1;
        res.kind = RK_ACK;
      end
    endcase
  end

endmodule
